// ===== hdl/pcx_pkg.sv =====
// Package for the PCX run-length stream decoder: types, constants and the
// command/status structs shared by the controller, datapath and config block.
// No dependencies.
package pcx_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_BYTES       = 3 * PALETTE_ENTRIES;
    localparam int PAL_IDX_W       = 10;
    localparam logic [PAL_IDX_W-1:0] PAL_LAST = PAL_IDX_W'(PAL_BYTES - 1);

    localparam int BYTE_W  = 8;
    localparam int FMT_W   = 2;
    localparam int RLEN_W  = 18;
    localparam int NROWS_W = 17;
    localparam int ROWIX_W = 16;
    localparam int COUNT_W = 6;

    localparam logic [BYTE_W-1:0] RUN_FLAGS    = 8'hC0;
    localparam logic [BYTE_W-1:0] RUN_COUNT    = 8'h3F;
    localparam logic [BYTE_W-1:0] TRAILER_MARK = 8'h0C;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_ROW_LENGTH   = 2'd1,
        REG_IMAGE_ROWS   = 2'd2
    } t_reg_index;

    typedef enum logic [FMT_W-1:0] {
        FMT_MONO     = 2'd0,
        FMT_PLANAR4  = 2'd1,
        FMT_PALETTE8 = 2'd2,
        FMT_RGB24    = 2'd3
    } t_pixel_format;

    localparam logic [RLEN_W-1:0]  RLEN_RESET  = 18'd640;
    localparam logic [NROWS_W-1:0] NROWS_RESET = 17'd480;

    typedef enum logic [1:0] {
        PH_IMAGE   = 2'd0,
        PH_TRAILER = 2'd1,
        PH_PALETTE = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic {
        CTL_ACCEPT = 1'b0,
        CTL_RUN    = 1'b1
    } t_ctl_state;

    typedef struct packed {
        t_pixel_format          pixel_format;
        logic [RLEN_W-1:0]      row_length;
        logic [NROWS_W-1:0]     image_rows;
    } t_cfg;

    typedef struct packed {
        logic take;   // input byte transfer this cycle
        logic step;   // emit one more byte of the current run
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;   // output register can load this cycle
        logic opens_run;  // the input byte would start a run of two or more
        logic run_ends;   // the current run step is the last one
    } t_dp_status;

endpackage

// ===== hdl/pcx_in_if.sv =====
// Input channel of the PCX decoder: one compressed byte per transfer.
// Depends on pcx_pkg.
interface pcx_in_if;
    logic                           valid;
    logic                           ready;
    logic [pcx_pkg::BYTE_W-1:0]     data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hdl/pcx_out_if.sv =====
// Output channel of the PCX decoder: one tagged decoded byte per transfer.
// Depends on pcx_pkg.
interface pcx_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [pcx_pkg::BYTE_W-1:0]     value;
    logic [pcx_pkg::ROWIX_W-1:0]    row_index;
    logic [pcx_pkg::RLEN_W-1:0]     column_index;
    logic                           image_end;
    logic                           stream_done;
    logic                           last_of_run;

    modport source (output valid, output kind, output value, output row_index,
                    output column_index, output image_end, output stream_done,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input value, input row_index,
                    input column_index, input image_end, input stream_done,
                    input last_of_run, output ready);
endinterface

// ===== hdl/pcx_cfg_regs.sv =====
// APB-style configuration registers of the PCX decoder.
// Depends on pcx_pkg.
module pcx_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcx_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pcx_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pcx_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output pcx_pkg::t_cfg                   o_cfg
);

    pcx_pkg::t_cfg          r_cfg;
    pcx_pkg::t_reg_index    w_index;
    logic                   w_write;

    assign w_index = pcx_pkg::t_reg_index'(paddr[3:2]);
    assign w_write = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= pcx_pkg::FMT_PALETTE8;
            r_cfg.row_length   <= pcx_pkg::RLEN_RESET;
            r_cfg.image_rows   <= pcx_pkg::NROWS_RESET;
        end else if (w_write) begin
            case (w_index)
                pcx_pkg::REG_PIXEL_FORMAT: begin
                    r_cfg.pixel_format <= pcx_pkg::t_pixel_format'(pwdata[1:0]);
                end
                pcx_pkg::REG_ROW_LENGTH: begin
                    r_cfg.row_length <= pwdata[pcx_pkg::RLEN_W-1:0];
                end
                pcx_pkg::REG_IMAGE_ROWS: begin
                    r_cfg.image_rows <= pwdata[pcx_pkg::NROWS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            pcx_pkg::REG_PIXEL_FORMAT: prdata = pcx_pkg::CFG_DATA_W'(r_cfg.pixel_format);
            pcx_pkg::REG_ROW_LENGTH:   prdata = pcx_pkg::CFG_DATA_W'(r_cfg.row_length);
            pcx_pkg::REG_IMAGE_ROWS:   prdata = pcx_pkg::CFG_DATA_W'(r_cfg.image_rows);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== hdl/pcx_ctrl.sv =====
// Controller of the PCX decoder: takes input bytes or steps through a run.
// Depends on pcx_pkg.
module pcx_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  pcx_pkg::t_dp_status     i_status,
    output logic                    o_in_ready,
    output pcx_pkg::t_dp_cmd        o_cmd
);

    pcx_pkg::t_ctl_state r_state;
    pcx_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcx_pkg::CTL_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcx_pkg::CTL_ACCEPT: begin
                if (i_in_valid && i_status.out_free && i_status.opens_run) begin
                    n_state = pcx_pkg::CTL_RUN;
                end
            end
            pcx_pkg::CTL_RUN: begin
                if (i_status.out_free && i_status.run_ends) begin
                    n_state = pcx_pkg::CTL_ACCEPT;
                end
            end
            default: n_state = pcx_pkg::CTL_ACCEPT;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pcx_pkg::CTL_ACCEPT: begin
                o_in_ready = i_status.out_free;
                o_cmd.take = i_in_valid && i_status.out_free;
            end
            pcx_pkg::CTL_RUN: begin
                o_cmd.step = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/pcx_datapath.sv =====
// Datapath of the PCX decoder: run decode, row/column/palette counters and
// the output register. Depends on pcx_pkg and pcx_out_if.
module pcx_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcx_pkg::t_cfg                   i_cfg,
    input  pcx_pkg::t_dp_cmd                i_cmd,
    input  logic [pcx_pkg::BYTE_W-1:0]      i_data_byte,
    output pcx_pkg::t_dp_status             o_status,
    pcx_out_if.source                       o_out_ch
);

    // control state
    pcx_pkg::t_phase                    r_phase, n_phase;
    logic                               r_awaiting, n_awaiting;
    logic [pcx_pkg::COUNT_W-1:0]        r_pending, n_pending;
    logic [pcx_pkg::COUNT_W-1:0]        r_run_left, n_run_left;
    logic [pcx_pkg::NROWS_W-1:0]        r_row, n_row;
    logic [pcx_pkg::RLEN_W-1:0]         r_col, n_col;
    logic [pcx_pkg::PAL_IDX_W-1:0]      r_pal, n_pal;
    logic                               r_out_valid, n_out_valid;

    // payload
    logic [pcx_pkg::BYTE_W-1:0]         r_run_val, n_run_val;
    logic                               r_kind, n_kind;
    logic [pcx_pkg::BYTE_W-1:0]         r_value, n_value;
    logic [pcx_pkg::ROWIX_W-1:0]        r_row_ix, n_row_ix;
    logic [pcx_pkg::RLEN_W-1:0]         r_col_ix, n_col_ix;
    logic                               r_img_end, n_img_end;
    logic                               r_done, n_done;
    logic                               r_last, n_last;

    logic [pcx_pkg::RLEN_W-1:0]         w_rlen;
    logic [pcx_pkg::NROWS_W-1:0]        w_nrows;
    logic [pcx_pkg::RLEN_W:0]           w_col_inc;
    logic [pcx_pkg::NROWS_W:0]          w_row_inc;
    logic                               w_row_end;
    logic                               w_img_end;
    logic                               w_pal_last;
    logic                               w_is_header;
    logic                               w_img_emit;
    logic                               w_pal_emit;
    logic                               w_emit_last;
    logic [pcx_pkg::BYTE_W-1:0]         w_emit_value;

    // zero limits behave as one
    assign w_rlen  = (i_cfg.row_length == '0) ? pcx_pkg::RLEN_W'(1) : i_cfg.row_length;
    assign w_nrows = (i_cfg.image_rows == '0) ? pcx_pkg::NROWS_W'(1) : i_cfg.image_rows;

    assign w_col_inc  = {1'b0, r_col} + (pcx_pkg::RLEN_W+1)'(1);
    assign w_row_inc  = {1'b0, r_row} + (pcx_pkg::NROWS_W+1)'(1);
    assign w_row_end  = w_col_inc >= {1'b0, w_rlen};
    assign w_img_end  = w_row_end && (w_row_inc >= {1'b0, w_nrows});
    assign w_pal_last = r_pal >= pcx_pkg::PAL_LAST;
    assign w_is_header = (i_data_byte & pcx_pkg::RUN_FLAGS) == pcx_pkg::RUN_FLAGS;

    assign o_status.out_free  = !r_out_valid || o_out_ch.ready;
    assign o_status.opens_run = (r_phase == pcx_pkg::PH_IMAGE) && r_awaiting
                                && (r_pending > pcx_pkg::COUNT_W'(1)) && !w_img_end;
    assign o_status.run_ends  = (r_run_left <= pcx_pkg::COUNT_W'(1)) || w_img_end;

    always_comb begin
        n_phase      = r_phase;
        n_awaiting   = r_awaiting;
        n_pending    = r_pending;
        n_run_left   = r_run_left;
        n_run_val    = r_run_val;
        n_row        = r_row;
        n_col        = r_col;
        n_pal        = r_pal;
        n_out_valid  = r_out_valid && !o_out_ch.ready;
        n_kind       = r_kind;
        n_value      = r_value;
        n_row_ix     = r_row_ix;
        n_col_ix     = r_col_ix;
        n_img_end    = r_img_end;
        n_done       = r_done;
        n_last       = r_last;
        w_img_emit   = 1'b0;
        w_pal_emit   = 1'b0;
        w_emit_last  = 1'b1;
        w_emit_value = i_data_byte;

        if (i_cmd.step) begin
            w_img_emit   = 1'b1;
            w_emit_value = r_run_val;
            w_emit_last  = (r_run_left == pcx_pkg::COUNT_W'(1)) || w_img_end;
            n_run_left   = r_run_left - pcx_pkg::COUNT_W'(1);
        end else if (i_cmd.take) begin
            case (r_phase)
                pcx_pkg::PH_IMAGE: begin
                    if (r_awaiting) begin
                        n_awaiting = 1'b0;
                        n_pending  = '0;
                        // a zero count swallows the value byte
                        if (r_pending != '0) begin
                            w_img_emit  = 1'b1;
                            w_emit_last = (r_pending == pcx_pkg::COUNT_W'(1)) || w_img_end;
                            n_run_left  = r_pending - pcx_pkg::COUNT_W'(1);
                            n_run_val   = i_data_byte;
                        end
                    end else if (w_is_header) begin
                        n_awaiting = 1'b1;
                        n_pending  = pcx_pkg::COUNT_W'(i_data_byte & pcx_pkg::RUN_COUNT);
                    end else begin
                        w_img_emit = 1'b1;
                    end
                end
                pcx_pkg::PH_TRAILER: begin
                    n_phase = (i_data_byte == pcx_pkg::TRAILER_MARK) ? pcx_pkg::PH_PALETTE
                                                                      : pcx_pkg::PH_DONE;
                end
                pcx_pkg::PH_PALETTE: begin
                    w_pal_emit = 1'b1;
                    if (w_pal_last) begin
                        n_phase = pcx_pkg::PH_DONE;
                    end else begin
                        n_pal = r_pal + pcx_pkg::PAL_IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end

        if (w_img_emit) begin
            if (w_img_end) begin
                n_phase    = (i_cfg.pixel_format == pcx_pkg::FMT_PALETTE8) ?
                             pcx_pkg::PH_TRAILER : pcx_pkg::PH_DONE;
                n_awaiting = 1'b0;
                n_pending  = '0;
                n_col      = '0;
                n_row      = w_row_inc[pcx_pkg::NROWS_W-1:0];
            end else if (w_row_end) begin
                n_col = '0;
                n_row = w_row_inc[pcx_pkg::NROWS_W-1:0];
            end else begin
                n_col = w_col_inc[pcx_pkg::RLEN_W-1:0];
            end
            n_out_valid = 1'b1;
            n_kind      = 1'b0;
            n_value     = w_emit_value;
            n_row_ix    = r_row[pcx_pkg::ROWIX_W-1:0];
            n_col_ix    = r_col;
            n_img_end   = w_img_end;
            n_done      = w_img_end && (i_cfg.pixel_format != pcx_pkg::FMT_PALETTE8);
            n_last      = w_emit_last;
        end

        if (w_pal_emit) begin
            n_out_valid = 1'b1;
            n_kind      = 1'b1;
            n_value     = i_data_byte;
            n_row_ix    = '0;
            n_col_ix    = pcx_pkg::RLEN_W'(r_pal);
            n_img_end   = 1'b0;
            n_done      = w_pal_last;
            n_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pcx_pkg::PH_IMAGE;
            r_awaiting  <= 1'b0;
            r_pending   <= '0;
            r_run_left  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_pal       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_awaiting  <= n_awaiting;
            r_pending   <= n_pending;
            r_run_left  <= n_run_left;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pal       <= n_pal;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_val <= n_run_val;
        r_kind    <= n_kind;
        r_value   <= n_value;
        r_row_ix  <= n_row_ix;
        r_col_ix  <= n_col_ix;
        r_img_end <= n_img_end;
        r_done    <= n_done;
        r_last    <= n_last;
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.kind         = r_kind;
    assign o_out_ch.value        = r_value;
    assign o_out_ch.row_index    = r_row_ix;
    assign o_out_ch.column_index = r_col_ix;
    assign o_out_ch.image_end    = r_img_end;
    assign o_out_ch.stream_done  = r_done;
    assign o_out_ch.last_of_run  = r_last;

    // once stopped, the decoder stays stopped until reset
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pcx_pkg::PH_DONE) |=> (r_phase == pcx_pkg::PH_DONE))
        else $error("decoder left the stopped phase");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_img_emit || w_pal_emit) |-> (!r_out_valid || o_out_ch.ready))
        else $error("output register overwritten");

    // the final result of the stream also closes its input's results
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_last)
        else $error("stream_done without last_of_run");

    // run bookkeeping is only live in the image phase
    a_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pcx_pkg::PH_IMAGE) |-> (!r_awaiting && r_pal <= pcx_pkg::PAL_LAST))
        else $error("run state outside image phase");

endmodule

// ===== hdl/pcx_rle_stream_decoder.sv =====
// Top level of the PCX run-length stream decoder: config registers,
// controller and datapath. Depends on pcx_pkg, pcx_in_if, pcx_out_if.
//
//  Channel     Dir  Protocol           Payload
//  i_in_ch     in   valid/ready        data_byte (compressed stream byte)
//  o_out_ch    out  valid/ready        kind, value, row_index, column_index,
//                                      image_end, stream_done, last_of_run
//  APB         in   psel/penable       pixel_format @0, row_length @4,
//                                      image_rows @8
//
// Flow: literal, run-header, trailer and palette bytes each transfer alone;
// after the run value of a run of N bytes transfers, the input is held off
// until the run is through, one decoded byte per cycle while the output
// register is free, from the single emit path into the output register.
// Reset: synchronous, active low; no clearing pass, the block is ready as soon
// as reset is released. Config takes defaults 2 / 640 / 480.
// Stalls: one output register; while it holds a result that the receiver does
// not take this cycle, the input waits, also for bytes that produce no result.
module pcx_rle_stream_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pcx_in_if.sink                          i_in_ch,
    pcx_out_if.source                       o_out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcx_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pcx_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pcx_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    pcx_pkg::t_cfg          w_cfg;
    pcx_pkg::t_dp_cmd       w_cmd;
    pcx_pkg::t_dp_status    w_status;
    logic                   w_in_ready;

    // register file; write it only while the decoder is idle, which the block itself does not enforce
    pcx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // chooses between taking a new byte and repeating the run value
    pcx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    assign i_in_ch.ready = w_in_ready;

    // decode, counters, tagging and the output register
    pcx_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_data_byte (i_in_ch.data_byte),
        .o_status    (w_status),
        .o_out_ch    (o_out_ch)
    );

endmodule

// ===== verif/pcx_rle_stream_decoder_test.sv =====
// Self-checking testbench for pcx_rle_stream_decoder: drives compressed PCX bytes,
// predicts each tagged decoded byte and checks every output transfer field by field.
// Depends on pcx_pkg, pcx_in_if, pcx_out_if and the decoder RTL.
`timescale 1ns / 100ps

module pcx_rle_stream_decoder_test;
    import pcx_pkg::*;

    localparam int    CLK_HALF_NS  = 10;
    localparam int    RST_CYCLES   = 9;
    localparam int    IDLE_PCT     = 23;
    localparam int    CHOKE_CYCLES = 300;   // long receiver hold-off
    localparam int    DRAIN_CYCLES = 8;     // quiet time before a register write
    localparam int    TAIL_CYCLES  = 80;    // longest run plus slack
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // One decoded byte as it appears on the output channel.
    typedef struct packed {
        logic                   kind;
        logic [BYTE_W-1:0]      value;
        logic [ROWIX_W-1:0]     row_index;
        logic [RLEN_W-1:0]      column_index;
        logic                   image_end;
        logic                   stream_done;
        logic                   last_of_run;
    } t_decoded;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    pcx_in_if  in_ch ();
    pcx_out_if out_ch ();

    pcx_rle_stream_decoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Compressed bytes waiting for the driver, and decoded bytes still owed by the block.
    logic [BYTE_W-1:0]  stream_bytes[$];
    t_decoded           decoded_q[$];

    int  fail_count    = 0;
    int  src_idle_pct  = IDLE_PCT;
    int  sink_idle_pct = IDLE_PCT;
    bit  byte_taken    = 1'b0;  // set at the edge where the offered byte transferred
    bit  choking       = 1'b0;  // receiver held off by the choke process
    event choke_go;

    // ------------------------------------------------------------------
    // Decoder shadow: configuration and stream state, reset values
    // ------------------------------------------------------------------
    t_pixel_format          fmt_cfg   = FMT_PALETTE8;
    logic [RLEN_W-1:0]      rlen_cfg  = RLEN_RESET;
    logic [NROWS_W-1:0]     nrows_cfg = NROWS_RESET;

    t_phase                 stage     = PH_IMAGE;
    logic                   run_armed = 1'b0;
    logic [COUNT_W-1:0]     run_count = '0;
    logic [NROWS_W-1:0]     row_ctr   = '0;
    logic [RLEN_W-1:0]      col_ctr   = '0;
    logic [PAL_IDX_W-1:0]   pal_ctr   = '0;

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Queues one image byte at the current row/column and advances the position.
    // Zero length or zero rows behave as one. Returns 1 when the image is complete.
    function automatic bit put_pixel(input logic [BYTE_W-1:0] v);
        int unsigned eff_len;
        int unsigned eff_rows;
        bit          row_end;
        bit          img_end;
        t_decoded    d;
        eff_len  = (rlen_cfg == '0) ? 1 : rlen_cfg;
        eff_rows = (nrows_cfg == '0) ? 1 : nrows_cfg;
        row_end  = (32'(col_ctr) + 1 >= eff_len);
        img_end  = row_end && (32'(row_ctr) + 1 >= eff_rows);
        d = '{kind: 1'b0, value: v, row_index: row_ctr[ROWIX_W-1:0], column_index: col_ctr,
              image_end: img_end, stream_done: 1'b0, last_of_run: 1'b0};
        if (img_end) begin
            // palette images go look for the marker, everything else stops here
            if (fmt_cfg == FMT_PALETTE8) begin
                stage = PH_TRAILER;
            end else begin
                stage = PH_DONE;
                d.stream_done = 1'b1;
            end
            run_armed = 1'b0;
            run_count = '0;
            col_ctr   = '0;
            row_ctr   = row_ctr + 1'b1;
        end else if (row_end) begin
            col_ctr = '0;
            row_ctr = row_ctr + 1'b1;
        end else begin
            col_ctr = col_ctr + 1'b1;
        end
        decoded_q.push_back(d);
        return img_end;
    endfunction

    // Works out everything one transferred input byte produces.
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        int       owed_before;
        int       k;
        bit       ended;
        t_decoded d;
        owed_before = decoded_q.size();
        ended = 1'b0;
        case (stage)
            PH_IMAGE: begin
                if (run_armed) begin
                    // run value: repeat it, dropping whatever is left past the image end
                    run_armed = 1'b0;
                    for (k = 0; k < int'(run_count) && !ended; k++)
                        ended = put_pixel(b);
                    run_count = '0;
                end else if ((b & RUN_FLAGS) == RUN_FLAGS) begin
                    run_armed = 1'b1;
                    run_count = COUNT_W'(b & RUN_COUNT);
                end else begin
                    void'(put_pixel(b));
                end
            end
            PH_TRAILER: begin
                stage = (b == TRAILER_MARK) ? PH_PALETTE : PH_DONE;
            end
            PH_PALETTE: begin
                d = '{kind: 1'b1, value: b, row_index: '0, column_index: RLEN_W'(pal_ctr),
                      image_end: 1'b0, stream_done: (pal_ctr >= PAL_LAST), last_of_run: 1'b0};
                decoded_q.push_back(d);
                if (d.stream_done)
                    stage = PH_DONE;
                else
                    pal_ctr = pal_ctr + 1'b1;
            end
            default: ;
        endcase
        if (decoded_q.size() > owed_before)
            decoded_q[decoded_q.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Input driver: a byte stays offered until it transfers; the next one may
    // follow back to back or after a random gap.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            decode_byte(in_ch.data_byte);
            byte_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!in_ch.valid || byte_taken) begin
            byte_taken = 1'b0;
            if (stream_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_ch.data_byte <= stream_bytes.pop_front();
                in_ch.valid     <= 1'b1;
            end else begin
                in_ch.valid     <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long choke on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_ch.ready <= !choking && ($urandom_range(99) >= sink_idle_pct);
    end

    initial begin
        forever begin
            @(choke_go);
            choking = 1'b1;
            repeat (CHOKE_CYCLES) @(posedge i_clk);
            choking = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: each transfer against the oldest owed byte
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_decoded want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            if (decoded_q.size() == 0) begin
                note_mismatch("transfer with nothing owed", 32'(out_ch.value), 32'd0);
            end else begin
                want = decoded_q.pop_front();
                if (out_ch.kind !== want.kind)
                    note_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
                if (out_ch.value !== want.value)
                    note_mismatch("value", 32'(out_ch.value), 32'(want.value));
                if (out_ch.row_index !== want.row_index)
                    note_mismatch("row_index", 32'(out_ch.row_index), 32'(want.row_index));
                if (out_ch.column_index !== want.column_index)
                    note_mismatch("column_index", 32'(out_ch.column_index),
                                  32'(want.column_index));
                if (out_ch.image_end !== want.image_end)
                    note_mismatch("image_end", 32'(out_ch.image_end), 32'(want.image_end));
                if (out_ch.stream_done !== want.stream_done)
                    note_mismatch("stream_done", 32'(out_ch.stream_done),
                                  32'(want.stream_done));
                if (out_ch.last_of_run !== want.last_of_run)
                    note_mismatch("last_of_run", 32'(out_ch.last_of_run),
                                  32'(want.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access over APB: setup cycle, then access until pready
    // ------------------------------------------------------------------
    task automatic check_reg(input t_reg_index idx, input logic [31:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want)
            note_mismatch($sformatf("readback of register %s", idx.name()), got, want);
    endtask

    task automatic program_reg(input t_reg_index idx, input logic [31:0] val);
        logic [31:0] want;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        // register takes the value at this edge; the shadow follows
        case (idx)
            REG_PIXEL_FORMAT: begin
                fmt_cfg = t_pixel_format'(val[FMT_W-1:0]);
                want    = 32'(fmt_cfg);
            end
            REG_ROW_LENGTH: begin
                rlen_cfg = val[RLEN_W-1:0];
                want     = 32'(rlen_cfg);
            end
            default: begin
                nrows_cfg = val[NROWS_W-1:0];
                want      = 32'(nrows_cfg);
            end
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_reg(idx, want);
    endtask

    // Config may only change once the block has gone quiet: every byte handed
    // over, every owed result seen, and a DRAIN_CYCLES wait for a trailing run header.
    task automatic wait_drained;
        while (stream_bytes.size() != 0 || in_ch.valid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------
    task automatic push_run(input int unsigned cnt, input logic [BYTE_W-1:0] v);
        stream_bytes.push_back(RUN_FLAGS | BYTE_W'(cnt));
        stream_bytes.push_back(v);
    endtask

    // Mostly literals and runs; a little raw noise that may open a run header.
    task automatic push_chunk;
        int pick;
        int len_pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            stream_bytes.push_back(BYTE_W'($urandom_range(255)));
        end else if (pick < 58) begin
            stream_bytes.push_back(BYTE_W'($urandom_range(191)));   // top bits never both set
        end else begin
            len_pick = $urandom_range(99);
            if (len_pick < 6)
                push_run(0, BYTE_W'($urandom_range(255)));
            else if (len_pick < 12)
                push_run(63, BYTE_W'($urandom_range(255)));
            else if (len_pick < 70)
                push_run($urandom_range(1, 4), BYTE_W'($urandom_range(255)));
            else
                push_run($urandom_range(1, 63), BYTE_W'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #(RUN_LIMIT_NS);
        $display("pcx_rle_stream_decoder test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset is applied once, so the whole run is one image. The image
    // is kept open with a huge row count while the config changes between
    // phases, and is closed in the last phase by one of the possible endings.
    // ------------------------------------------------------------------
    initial begin
        int                   p;
        int                   ending;
        logic [BYTE_W-1:0]    b;
        logic [NROWS_W-1:0]   end_rows;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of the registers
        check_reg(REG_PIXEL_FORMAT, 32'(FMT_PALETTE8));
        check_reg(REG_ROW_LENGTH, 32'(RLEN_RESET));
        check_reg(REG_IMAGE_ROWS, 32'(NROWS_RESET));

        // Directed: short rows so runs wrap rows; field extremes on the data byte.
        program_reg(REG_PIXEL_FORMAT, 32'(FMT_MONO));
        program_reg(REG_ROW_LENGTH, 32'd5);
        program_reg(REG_IMAGE_ROWS, 32'h1FFFF);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hBF);
        stream_bytes.push_back(8'h7F);
        stream_bytes.push_back(8'h40);
        push_run(0, 8'hFF);         // zero count: value byte swallowed, nothing out
        push_run(1, 8'h00);
        push_run(63, 8'hAA);        // longest run, crosses several row ends
        push_run(3, 8'hC0);         // run value that looks like a header
        push_run(2, 8'h55);
        stream_bytes.push_back(8'h3C);
        stream_bytes.push_back(8'h80);
        stream_bytes.push_back(8'h01);
        wait_drained();

        // Row length changes mid-row: widest value first, then below the column.
        program_reg(REG_PIXEL_FORMAT, 32'(FMT_PLANAR4));
        program_reg(REG_ROW_LENGTH, 32'h3FFFF);
        push_run(8, 8'h11);
        wait_drained();
        program_reg(REG_ROW_LENGTH, 32'd2);     // column already past: next byte ends row
        stream_bytes.push_back(8'h22);
        stream_bytes.push_back(8'h33);
        wait_drained();
        program_reg(REG_ROW_LENGTH, 32'd0);     // zero length acts as one
        program_reg(REG_IMAGE_ROWS, 32'd65536);
        push_run(4, 8'h44);
        wait_drained();

        // Random phases, each with its own format and row length.
        for (p = 0; p < 7; p++) begin
            program_reg(REG_PIXEL_FORMAT, 32'(p % 4));
            if (p == 3)
                program_reg(REG_ROW_LENGTH, 32'd262140);
            else if (p == 5)
                program_reg(REG_ROW_LENGTH, 32'd1);
            else
                program_reg(REG_ROW_LENGTH, 32'($urandom_range(0, 24)));
            program_reg(REG_IMAGE_ROWS, (p % 2) ? 32'd65536 : 32'h1FFFF);
            // one phase runs with neither side idling
            src_idle_pct  = (p == 1) ? 0 : IDLE_PCT;
            sink_idle_pct = (p == 1) ? 0 : IDLE_PCT;
            repeat (42) push_chunk();
            // receiver chokes while the sender keeps a full queue on offer
            if (p == 2)
                -> choke_go;
            wait_drained();
        end
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;

        // Closing phase: shrink the image so the next row end finishes it,
        // mid-run, so the rest of that run is dropped.
        ending = $urandom_range(3);
        if (ending <= 1 || ending == 2)
            program_reg(REG_PIXEL_FORMAT, 32'(FMT_PALETTE8));
        else
            program_reg(REG_PIXEL_FORMAT, 32'($urandom_range(2) == 0 ? FMT_MONO :
                                              ($urandom_range(1) ? FMT_PLANAR4 : FMT_RGB24)));
        program_reg(REG_ROW_LENGTH, 32'($urandom_range(1, 3)));
        case ($urandom_range(2))
            0:       end_rows = '0;
            1:       end_rows = 17'd1;
            default: end_rows = (row_ctr == '1) ? row_ctr : row_ctr + 1'b1;
        endcase
        program_reg(REG_IMAGE_ROWS, 32'(end_rows));
        push_run(63, BYTE_W'($urandom_range(255)));

        if (ending <= 1) begin
            // marker, full palette, then bytes the stopped decoder must drop
            stream_bytes.push_back(TRAILER_MARK);
            repeat (PAL_BYTES) stream_bytes.push_back(BYTE_W'($urandom_range(255)));
            repeat (8) stream_bytes.push_back(BYTE_W'($urandom_range(255)));
        end else begin
            // wrong marker on a palette image, or trailing junk after any other
            // image: nothing more comes out either way
            b = BYTE_W'($urandom_range(255));
            if (b == TRAILER_MARK)
                b = b + 1'b1;
            stream_bytes.push_back(b);
            stream_bytes.push_back(TRAILER_MARK);
            repeat (16) stream_bytes.push_back(BYTE_W'($urandom_range(255)));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("pcx_rle_stream_decoder test passed");
        else
            $display("pcx_rle_stream_decoder test failed");
        $finish;
    end

endmodule

// ===== pcx_rle_stream_decoder.f =====
hdl/pcx_pkg.sv
hdl/pcx_in_if.sv
hdl/pcx_out_if.sv
hdl/pcx_cfg_regs.sv
hdl/pcx_ctrl.sv
hdl/pcx_datapath.sv
hdl/pcx_rle_stream_decoder.sv
verif/pcx_rle_stream_decoder_test.sv
